FILE: hw/rtl/ibw_pkg.sv
// ============================================================================
// ibw_pkg: shared types and constants of the image byte writer
// Command codes, controller states and the command/status structures.
// ============================================================================
`default_nettype none
package ibw_pkg;
    localparam int unsigned IMAGE_DEPTH_DEF     = 65536;
    localparam int unsigned MAX_INSERT_BITS_DEF = 32;
    localparam logic [16:0] ROM_SIZE_RST        = 17'd65536;
    localparam logic [16:0] BANK_SIZE_RST       = 17'd16384;

    typedef enum logic [2:0] {
        CMD_WRITE     = 3'd0,
        CMD_ALLOW     = 3'd1,
        CMD_CHECKED   = 3'd2,
        CMD_LOW5      = 3'd3,
        CMD_POSITION  = 3'd4,
        CMD_BITS      = 3'd5,
        CMD_SET_POS   = 3'd6,
        CMD_NONE      = 3'd7
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_RANGE  = 2'd1,
        ST_SLOT   = 2'd2,
        ST_BANK   = 2'd3
    } status_t;

    localparam logic [0:0] CFG_ROM_SIZE  = 1'b0;
    localparam logic [0:0] CFG_BANK_SIZE = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_MODIFY,
        S_BIT_READ,
        S_BIT_WRITE,
        S_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;   // write zero at clear address, advance it
        logic capture;      // register the input transaction
        logic rd_target;    // issue read at target address
        logic modify;       // apply byte command to read data
        logic bit_rd;       // issue read of current insert byte
        logic bit_wr;       // OR bits into insert byte, advance
        logic res_load;     // move result into output register
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_done;
        logic is_bits;      // captured command is a bit insert that goes ahead
        logic is_mem;       // captured command touches the store
        logic bits_last;    // current insert byte is the last one
    } dp_stat_t;
endpackage
`default_nettype wire

FILE: hw/rtl/ibw_ram.sv
// ============================================================================
// ibw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none
module ibw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ibw_ctrl.sv
// ============================================================================
// ibw_ctrl: command sequencer
// Steps the clearing pass, the read-modify-write and the bit insert loop.
// ============================================================================
`default_nettype none
module ibw_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic             out_free,
    input  wire ibw_pkg::dp_stat_t stat,
    output ibw_pkg::dp_cmd_t      cmd
);
    ibw_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ibw_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ibw_pkg::S_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_done)
                begin
                    state_next = ibw_pkg::S_IDLE;
                end
            end
            ibw_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ibw_pkg::S_READ;
                end
            end
            ibw_pkg::S_READ:
            begin
                cmd.rd_target = 1'b1;
                state_next    = ibw_pkg::S_MODIFY;
            end
            ibw_pkg::S_MODIFY:
            begin
                // read data is valid now: the result takes the old byte
                if (stat.is_bits)
                begin
                    cmd.bit_rd = 1'b1;
                    state_next = ibw_pkg::S_BIT_WRITE;
                end
                else
                begin
                    cmd.modify = 1'b1;
                    state_next = ibw_pkg::S_RESULT;
                end
            end
            ibw_pkg::S_BIT_READ:
            begin
                cmd.bit_rd = 1'b1;
                state_next = ibw_pkg::S_BIT_WRITE;
            end
            ibw_pkg::S_BIT_WRITE:
            begin
                cmd.bit_wr = 1'b1;
                state_next = stat.bits_last ? ibw_pkg::S_RESULT : ibw_pkg::S_BIT_READ;
            end
            ibw_pkg::S_RESULT:
            begin
                if (out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ibw_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ibw_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: hw/rtl/ibw_datapath.sv
// ============================================================================
// ibw_datapath: store, counters, positions and result formation
// Holds the byte and usage memories and applies each command to them.
// ============================================================================
`default_nettype none
module ibw_datapath #(
    parameter int unsigned IMAGE_DEPTH     = ibw_pkg::IMAGE_DEPTH_DEF,
    parameter int unsigned MAX_INSERT_BITS = ibw_pkg::MAX_INSERT_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ibw_pkg::dp_cmd_t  cmd,
    output ibw_pkg::dp_stat_t      stat,
    input  wire logic [2:0]        in_cmd,
    input  wire logic [15:0]       in_address,
    input  wire logic [31:0]       in_value,
    input  wire logic [7:0]        in_allowed,
    input  wire logic [2:0]        in_bit_offset,
    input  wire logic [5:0]        in_bit_count,
    input  wire logic              in_overwrite,
    input  wire logic [15:0]       in_slot_start,
    input  wire logic [15:0]       in_bank_start,
    input  wire logic [15:0]       in_slot_end,
    input  wire logic [16:0]       rom_size,
    input  wire logic [16:0]       bank_size,
    output logic [1:0]             res_status,
    output logic                   res_conflict,
    output logic [7:0]             res_old_byte,
    output logic [15:0]            res_target
);
    localparam int unsigned AW = $clog2(IMAGE_DEPTH);
    localparam int unsigned CW = $clog2(MAX_INSERT_BITS + 1);
    // widest span in bits: offset 7 plus the longest insert
    localparam int unsigned SPAN = MAX_INSERT_BITS + 7;
    localparam int unsigned NBW  = $clog2((SPAN + 7) / 8 + 1);

    // captured transaction
    logic [2:0]  c_cmd_reg;
    logic [15:0] c_addr_reg;
    logic [31:0] c_val_reg;
    logic [7:0]  c_allow_reg;
    logic [2:0]  c_off_reg;
    logic [CW-1:0] c_cnt_reg;
    logic        c_ovw_reg;

    logic [15:0] pos_reg, slot_reg, bank_reg, limit_reg;
    logic [AW:0] clr_reg;
    logic [1:0]  status_reg;
    logic        conflict_reg;
    logic [7:0]  old_reg;
    logic [15:0] target_reg;
    logic [NBW-1:0] byte_idx_reg;
    logic [NBW-1:0] byte_last;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wbyte, wuse, rbyte, ruse;

    logic [CW-1:0] cnt_sat;
    logic [AW-1:0] tgt_idx;
    logic          range_bad, slot_bad, bank_bad, rejected, bits_go;

    assign cnt_sat = (32'(in_bit_count) > MAX_INSERT_BITS) ? CW'(MAX_INSERT_BITS)
                                                           : CW'(in_bit_count);
    assign tgt_idx   = (c_cmd_reg == ibw_pkg::CMD_POSITION) ? AW'(pos_reg) : AW'(c_addr_reg);
    assign range_bad = {1'b0, c_addr_reg} >= rom_size;
    assign slot_bad  = slot_reg >= limit_reg;
    assign bank_bad  = {1'b0, bank_reg} >= bank_size;
    assign bits_go   = (c_cmd_reg == ibw_pkg::CMD_BITS) && !range_bad && (c_cnt_reg != '0);
    assign byte_last = NBW'((32'(c_off_reg) + 32'(c_cnt_reg) - 32'd1) >> 3);

    assign stat.clear_done = clr_reg == (AW + 1)'(IMAGE_DEPTH - 1);
    assign stat.is_bits    = bits_go;
    assign stat.is_mem     = c_cmd_reg <= ibw_pkg::CMD_BITS;
    assign stat.bits_last  = byte_idx_reg == byte_last;

    // insert bits of the value falling into the current byte, MSB first
    function automatic logic [7:0] ins_bits(input logic [2:0] off, input logic [CW-1:0] cnt,
                                            input logic [31:0] v, input logic [NBW-1:0] bi);
        logic [7:0]  r;
        int unsigned pos, src;
        r = '0;
        for (int b = 0; b < 8; b++)
        begin
            pos = 32'(bi) * 8 + 32'(b);
            if (pos >= 32'(off) && pos < 32'(off) + 32'(cnt))
            begin
                src = 32'(cnt) - 1 - (pos - 32'(off));
                if (src < 32)
                begin
                    r[7-b] = v[src[4:0]];
                end
            end
        end
        return r;
    endfunction

    // RAM port selection and write data
    always_comb
    begin
        we    = 1'b0;
        waddr = tgt_idx;
        wbyte = rbyte;
        wuse  = ruse;
        raddr = tgt_idx;
        rejected = 1'b0;
        if (cmd.clear_step)
        begin
            we    = 1'b1;
            waddr = clr_reg[AW-1:0];
            wbyte = '0;
            wuse  = '0;
        end
        else if (cmd.modify)
        begin
            priority case (c_cmd_reg)
                ibw_pkg::CMD_WRITE, ibw_pkg::CMD_ALLOW:
                begin
                    wbyte = c_val_reg[7:0];
                    wuse  = ruse + 8'd1;
                end
                ibw_pkg::CMD_CHECKED:
                begin
                    rejected = range_bad;
                    wbyte = c_val_reg[7:0];
                    wuse  = ruse + 8'd1;
                end
                ibw_pkg::CMD_LOW5:
                begin
                    rejected = range_bad;
                    wbyte = {rbyte[7:5], c_val_reg[4:0]};
                    wuse  = ruse + 8'd1;
                end
                ibw_pkg::CMD_POSITION:
                begin
                    rejected = slot_bad || bank_bad;
                    wbyte = c_val_reg[7:0];
                    wuse  = c_ovw_reg ? 8'd1 : ruse + 8'd1;
                end
                default:
                begin
                    rejected = 1'b1;
                end
            endcase
            we = !rejected;
        end
        else if (cmd.bit_rd || cmd.bit_wr)
        begin
            waddr = AW'(c_addr_reg) + AW'(byte_idx_reg);
            raddr = waddr;
            wbyte = rbyte | ins_bits(c_off_reg, c_cnt_reg, c_val_reg, byte_idx_reg);
            we    = cmd.bit_wr;
        end
    end

    ibw_ram #(.WIDTH(8), .DEPTH(IMAGE_DEPTH)) u_bytes (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wbyte), .raddr(raddr), .rdata(rbyte)
    );
    ibw_ram #(.WIDTH(8), .DEPTH(IMAGE_DEPTH)) u_usage (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wuse), .raddr(raddr), .rdata(ruse)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg   <= '0;
            pos_reg   <= '0;
            slot_reg  <= '0;
            bank_reg  <= '0;
            limit_reg <= '0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.capture && in_cmd == ibw_pkg::CMD_SET_POS)
            begin
                pos_reg   <= in_address;
                slot_reg  <= in_slot_start;
                bank_reg  <= in_bank_start;
                limit_reg <= in_slot_end;
            end
            if (cmd.modify && c_cmd_reg == ibw_pkg::CMD_POSITION && !rejected)
            begin
                pos_reg  <= pos_reg + 16'd1;
                slot_reg <= slot_reg + 16'd1;
                bank_reg <= bank_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            c_cmd_reg    <= in_cmd;
            c_addr_reg   <= in_address;
            c_val_reg    <= in_value;
            c_allow_reg  <= in_allowed;
            c_off_reg    <= in_bit_offset;
            c_cnt_reg    <= cnt_sat;
            c_ovw_reg    <= in_overwrite;
            byte_idx_reg <= '0;
            status_reg   <= ibw_pkg::ST_OK;
            conflict_reg <= 1'b0;
            old_reg      <= '0;
            target_reg   <= (in_cmd == ibw_pkg::CMD_NONE) ? 16'd0
                          : (in_cmd == ibw_pkg::CMD_POSITION) ? pos_reg : in_address;
        end
        if (cmd.bit_wr)
        begin
            byte_idx_reg <= byte_idx_reg + 1'b1;
        end
        if (cmd.bit_rd && byte_idx_reg == '0 && !stat.is_mem)
        begin
            old_reg <= '0;
        end
        if ((cmd.modify || (cmd.bit_rd && byte_idx_reg == '0)) && stat.is_mem)
        begin
            old_reg <= rbyte;
        end
        if (cmd.modify)
        begin
            priority case (c_cmd_reg)
                ibw_pkg::CMD_WRITE:
                    conflict_reg <= (ruse != 8'd0) && (rbyte != c_val_reg[7:0]);
                ibw_pkg::CMD_ALLOW:
                    conflict_reg <= (ruse > c_allow_reg) && (ruse != 8'd0)
                                    && (rbyte != c_val_reg[7:0]);
                ibw_pkg::CMD_CHECKED:
                begin
                    status_reg   <= range_bad ? ibw_pkg::ST_RANGE : ibw_pkg::ST_OK;
                    conflict_reg <= !range_bad && (ruse > 8'd1) && (rbyte != c_val_reg[7:0]);
                end
                ibw_pkg::CMD_LOW5:
                begin
                    status_reg   <= range_bad ? ibw_pkg::ST_RANGE : ibw_pkg::ST_OK;
                    conflict_reg <= !range_bad && (ruse > 8'd1)
                                    && (rbyte[4:0] != c_val_reg[4:0]);
                end
                ibw_pkg::CMD_POSITION:
                begin
                    status_reg   <= slot_bad ? ibw_pkg::ST_SLOT
                                  : bank_bad ? ibw_pkg::ST_BANK : ibw_pkg::ST_OK;
                    conflict_reg <= !slot_bad && !bank_bad && !c_ovw_reg
                                    && (ruse != 8'd0) && (rbyte != c_val_reg[7:0]);
                end
                ibw_pkg::CMD_BITS:
                    status_reg <= range_bad ? ibw_pkg::ST_RANGE : ibw_pkg::ST_OK;
                default:
                begin
                    old_reg <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status   <= status_reg;
            res_conflict <= conflict_reg;
            res_old_byte <= old_reg;
            res_target   <= target_reg;
        end
    end
endmodule
`default_nettype wire

FILE: hw/rtl/image_byte_writer_with_usage.sv
// ============================================================================
// image_byte_writer_with_usage: image byte store with usage counters
// Top level: stream ports, configuration registers, controller and datapath.
// ============================================================================
// After reset the block runs a clearing pass over all IMAGE_DEPTH entries (65536 by
// default) that zeroes the byte store and the usage counters; it accepts no
// transaction until that pass is done, though configuration writes are taken.
// Each command is a read-modify-write on the byte and usage stores: a byte
// command steps through accept, read, modify and result, and a bit insert
// steps through accept, read, then a bit read and a bit write for each byte
// that it spans, then result; a 32-bit insert can span up to five bytes. One
// command is in flight at a time; the result sits in an output register so
// that the next command may be accepted while it waits.
`default_nettype none
module image_byte_writer_with_usage #(
    parameter int unsigned IMAGE_DEPTH     = ibw_pkg::IMAGE_DEPTH_DEF,
    parameter int unsigned MAX_INSERT_BITS = ibw_pkg::MAX_INSERT_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // cmd[2:0], address[18:3], value[50:19], overwrite_allowance[58:51],
    // bit_offset[61:59], bit_count[67:62], overwrite_mode[68],
    // slot_start[84:69], bank_start[100:85], slot_end[116:101], zero fill
    input  wire logic [119:0] s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // status[1:0], conflict[2], old_byte[10:3], target_address[26:11], zero fill
    output logic [31:0]      m_axis_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [16:0] cfg_data
);
    logic [16:0] rom_size_reg, bank_size_reg;
    logic        out_valid_reg;
    logic        in_ready;
    logic        out_free;
    ibw_pkg::dp_cmd_t  dp_cmd;
    ibw_pkg::dp_stat_t dp_stat;
    logic [1:0]  res_status;
    logic        res_conflict;
    logic [7:0]  res_old_byte;
    logic [15:0] res_target;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = in_ready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, res_target, res_old_byte, res_conflict, res_status};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_size_reg  <= ibw_pkg::ROM_SIZE_RST;
            bank_size_reg <= ibw_pkg::BANK_SIZE_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_index == ibw_pkg::CFG_ROM_SIZE)
            begin
                rom_size_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == ibw_pkg::CFG_BANK_SIZE)
            begin
                bank_size_reg <= cfg_data;
            end
            if (dp_cmd.res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    ibw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(in_ready),
        .out_free(out_free), .stat(dp_stat), .cmd(dp_cmd)
    );

    ibw_datapath #(.IMAGE_DEPTH(IMAGE_DEPTH), .MAX_INSERT_BITS(MAX_INSERT_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(dp_cmd), .stat(dp_stat),
        .in_cmd(s_axis_tdata[2:0]), .in_address(s_axis_tdata[18:3]),
        .in_value(s_axis_tdata[50:19]), .in_allowed(s_axis_tdata[58:51]),
        .in_bit_offset(s_axis_tdata[61:59]), .in_bit_count(s_axis_tdata[67:62]),
        .in_overwrite(s_axis_tdata[68]), .in_slot_start(s_axis_tdata[84:69]),
        .in_bank_start(s_axis_tdata[100:85]), .in_slot_end(s_axis_tdata[116:101]),
        .rom_size(rom_size_reg), .bank_size(bank_size_reg),
        .res_status(res_status), .res_conflict(res_conflict),
        .res_old_byte(res_old_byte), .res_target(res_target)
    );

    // A result is only loaded when the output register is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.res_load |-> out_free)
        else $error("result loaded over a waiting transaction");

    // A new transaction is never taken while the store is being written.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !dp_cmd.bit_wr && !dp_cmd.modify && !dp_cmd.clear_step)
        else $error("input accepted during store update");

    // A result appears only after an accepted transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(dp_cmd.res_load))
        else $error("result without a command");
endmodule
`default_nettype wire
